### hdl/rcs_pkg.sv
// Shared types and constants for the RC servo pulse shaper.
package rcs_pkg;

  localparam int POSITION_FRAC_BITS = 14;
  localparam int PULSE_W            = 16;
  localparam int POS_W              = 16;
  localparam int CHAN_W             = 4;
  localparam int PROD_W             = PULSE_W + POS_W;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 16;
  localparam int IN_TDATA_W         = PULSE_W + POS_W;
  localparam int OUT_TDATA_W        = ((PULSE_W + CHAN_W + 7) / 8) * 8;

  localparam logic signed [POS_W-1:0]  POS_ONE  = POS_W'(1 << POSITION_FRAC_BITS);
  localparam logic signed [PROD_W-1:0] POS_BIAS = PROD_W'((1 << POSITION_FRAC_BITS) - 1);

  localparam logic [PULSE_W-1:0] RST_PULSE_MIN     = 16'd1000;
  localparam logic [PULSE_W-1:0] RST_PULSE_MAX     = 16'd2000;
  localparam logic [PULSE_W-1:0] RST_PULSE_NEUTRAL = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_MIN      = 3'd0,
    REG_PULSE_MAX      = 3'd1,
    REG_PULSE_NEUTRAL  = 3'd2,
    REG_DEAD_BAND      = 3'd3,
    REG_SMOOTH_ENABLE  = 3'd4,
    REG_REVERSE_ENABLE = 3'd5,
    REG_CHANNEL_NUMBER = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
    logic [PULSE_W-1:0] pulse_neutral;
    logic [PULSE_W-1:0] dead_band;
    logic               smooth_enable;
    logic               reverse_enable;
    logic [CHAN_W-1:0]  channel_number;
  } rcs_cfg_t;

endpackage

### hdl/rcs_cfg.sv
// Configuration register file for the RC servo pulse shaper.
module rcs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output rcs_pkg::rcs_cfg_t              cfg
);

  rcs_pkg::rcs_cfg_t cfg_r;
  rcs_pkg::rcs_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        rcs_pkg::REG_PULSE_MIN:      cfg_nxt.pulse_min      = cfg_data[rcs_pkg::PULSE_W-1:0];
        rcs_pkg::REG_PULSE_MAX:      cfg_nxt.pulse_max      = cfg_data[rcs_pkg::PULSE_W-1:0];
        rcs_pkg::REG_PULSE_NEUTRAL:  cfg_nxt.pulse_neutral  = cfg_data[rcs_pkg::PULSE_W-1:0];
        rcs_pkg::REG_DEAD_BAND:      cfg_nxt.dead_band      = cfg_data[rcs_pkg::PULSE_W-1:0];
        rcs_pkg::REG_SMOOTH_ENABLE:  cfg_nxt.smooth_enable  = cfg_data[0];
        rcs_pkg::REG_REVERSE_ENABLE: cfg_nxt.reverse_enable = cfg_data[0];
        rcs_pkg::REG_CHANNEL_NUMBER: cfg_nxt.channel_number = cfg_data[rcs_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min      <= rcs_pkg::RST_PULSE_MIN;
      cfg_r.pulse_max      <= rcs_pkg::RST_PULSE_MAX;
      cfg_r.pulse_neutral  <= rcs_pkg::RST_PULSE_NEUTRAL;
      cfg_r.dead_band      <= '0;
      cfg_r.smooth_enable  <= 1'b0;
      cfg_r.reverse_enable <= 1'b0;
      cfg_r.channel_number <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/rcs_scale.sv
// Input register and position-to-pulse scaling stage; pulse commands pass through unscaled.
module rcs_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rcs_pkg::rcs_cfg_t              cfg,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rcs_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]                     in_tuser,
  output logic                           mid_valid,
  input  logic                           mid_ready,
  output logic [rcs_pkg::PULSE_W-1:0]    mid_pulse
);

  logic                                in_valid_r;
  logic                                cmd_r;
  logic        [rcs_pkg::PULSE_W-1:0]  pulse_r;
  logic signed [rcs_pkg::POS_W-1:0]    pos_r;
  logic                                mid_valid_r;
  logic        [rcs_pkg::PULSE_W-1:0]  mid_pulse_r;

  logic                                mid_free;
  logic signed [rcs_pkg::POS_W-1:0]    pos_clamp;
  logic signed [rcs_pkg::POS_W-1:0]    span;
  logic signed [rcs_pkg::PROD_W-1:0]   prod;
  logic signed [rcs_pkg::PROD_W-1:0]   prod_adj;
  logic signed [rcs_pkg::PROD_W-1:0]   offset;
  logic        [rcs_pkg::PULSE_W-1:0]  scaled;
  logic        [rcs_pkg::PULSE_W-1:0]  mid_pulse_nxt;

  assign mid_free  = !mid_valid_r || mid_ready;
  assign in_tready = !in_valid_r || mid_free;
  assign mid_valid = mid_valid_r;
  assign mid_pulse = mid_pulse_r;

  always_comb begin
    if (pos_r > rcs_pkg::POS_ONE) begin
      pos_clamp = rcs_pkg::POS_ONE;
    end else if (pos_r < -rcs_pkg::POS_ONE) begin
      pos_clamp = -rcs_pkg::POS_ONE;
    end else begin
      pos_clamp = pos_r;
    end
    span = pos_clamp[rcs_pkg::POS_W-1] ? $signed(cfg.pulse_neutral - cfg.pulse_min)
                                       : $signed(cfg.pulse_max - cfg.pulse_neutral);
    prod     = pos_clamp * span;
    // truncate toward zero
    prod_adj = prod + (prod[rcs_pkg::PROD_W-1] ? rcs_pkg::POS_BIAS : '0);
    offset   = prod_adj >>> rcs_pkg::POSITION_FRAC_BITS;
    scaled   = cfg.pulse_neutral + offset[rcs_pkg::PULSE_W-1:0];
    mid_pulse_nxt = cmd_r ? scaled : pulse_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      mid_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (mid_free) mid_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser[0];
      pulse_r <= in_tdata[rcs_pkg::PULSE_W-1:0];
      pos_r   <= $signed(in_tdata[rcs_pkg::IN_TDATA_W-1:rcs_pkg::PULSE_W]);
    end
    if (mid_free && in_valid_r) mid_pulse_r <= mid_pulse_nxt;
  end

endmodule

### hdl/rcs_shape.sv
// Pulse shaping stage: reverse, smoothing, dead band, clamp and output register.
module rcs_shape (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rcs_pkg::rcs_cfg_t               cfg,
  input  logic                            mid_valid,
  output logic                            mid_ready,
  input  logic [rcs_pkg::PULSE_W-1:0]     mid_pulse,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rcs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                          out_valid_r;
  logic [rcs_pkg::PULSE_W-1:0]   out_pulse_r;
  logic [rcs_pkg::CHAN_W-1:0]    out_chan_r;
  logic [rcs_pkg::PULSE_W-1:0]   last_pulse_r;

  logic [rcs_pkg::PULSE_W-1:0]   p_rev;
  logic [rcs_pkg::PULSE_W:0]     p_sum;
  logic [rcs_pkg::PULSE_W-1:0]   p_avg;
  logic [rcs_pkg::PULSE_W-1:0]   diff;
  logic [rcs_pkg::PULSE_W-1:0]   p_db;
  logic [rcs_pkg::PULSE_W-1:0]   p_hi;
  logic [rcs_pkg::PULSE_W-1:0]   shaped_nxt;
  logic                          take;

  assign mid_ready  = !out_valid_r || out_tready;
  assign take       = mid_valid && mid_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rcs_pkg::OUT_TDATA_W - rcs_pkg::PULSE_W - rcs_pkg::CHAN_W){1'b0}},
                       out_chan_r, out_pulse_r};

  always_comb begin
    p_rev = cfg.reverse_enable ? {cfg.pulse_neutral[rcs_pkg::PULSE_W-2:0], 1'b0} - mid_pulse
                               : mid_pulse;
    p_sum = {1'b0, p_rev} + {1'b0, last_pulse_r};
    p_avg = (cfg.smooth_enable && (last_pulse_r != '0)) ? p_sum[rcs_pkg::PULSE_W:1] : p_rev;
    diff  = (p_avg > cfg.pulse_neutral) ? p_avg - cfg.pulse_neutral
                                        : cfg.pulse_neutral - p_avg;
    p_db  = (diff < cfg.dead_band) ? cfg.pulse_neutral : p_avg;
    p_hi  = (p_db > cfg.pulse_max) ? cfg.pulse_max : p_db;
    shaped_nxt = (p_hi < cfg.pulse_min) ? cfg.pulse_min : p_hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      last_pulse_r <= '0;
    end else begin
      if (mid_ready) out_valid_r <= mid_valid;
      if (take) last_pulse_r <= shaped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pulse_r <= shaped_nxt;
      out_chan_r  <= cfg.channel_number;
    end
  end

endmodule

### hdl/rc_servo_pwm_shaper.sv
// RC servo pulse shaper top level: takes pulses or positions, emits shaped pulses.
// Accepts one item per clock while the output is not stalled and returns one result
// per item, in order, through an input register, a scaling stage holding the single
// 16x16 multiplier, and the shaping stage whose smoothing feeds back the previous
// output through one register and that registers the result. Backpressure on
// out_tready holds up to three items in flight before in_tready drops. cfg_ready is
// always high; write registers only while the block is idle.
module rc_servo_pwm_shaper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rcs_pkg::IN_TDATA_W-1:0]  in_tdata,   // pulse_in[15:0], position_in[31:16]
  input  logic [0:0]                      in_tuser,   // command[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rcs_pkg::OUT_TDATA_W-1:0] out_tdata,  // pulse_out[15:0], channel_out[19:16]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rcs_pkg::rcs_cfg_t            cfg;
  logic                         mid_valid;
  logic                         mid_ready;
  logic [rcs_pkg::PULSE_W-1:0]  mid_pulse;

  rcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcs_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_pulse (mid_pulse)
  );

  rcs_shape u_shape (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid_pulse  (mid_pulse),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hdl/rc_servo_pwm_shaper_chk.sv
// Port-level checker for the RC servo pulse shaper, bound to the top level.
module rc_servo_pwm_shaper_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rcs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // pipeline is empty straight after reset
  a_rst_out_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_rst_in_ready: assert property (@(posedge clk) $past(!rst_n) |-> in_tready)
    else $error("in_tready low after reset");

  // input only backs up once every stage is full and the output is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("in_tready low without output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output transfer changed");

endmodule

bind rc_servo_pwm_shaper rc_servo_pwm_shaper_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
